@@ hdl/mcbd_pkg.sv @@
// Shared types, constants and the gamma helper for the mip-chain box downsampler.
// No dependencies; every other file but mcbd_ram imports this package.
package mcbd_pkg;

  localparam int CH_W        = 16;
  localparam int IN_CH       = 4;
  localparam int SRGB_CH     = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int LVL_OUT_W   = 4;
  localparam int POS_OUT_W   = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NCH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S16    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRGB   = 3'd4;

  typedef enum logic [1:0] {
    ACT_DROP,
    ACT_STORE,
    ACT_HOLD,
    ACT_EMIT
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
    logic      same_row;
    logic      same_col;
    logic      final_px;
  } cell_info_t;

  // restoring long division, shift and subtract per quotient bit
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(2^lb * n^2 * r / (d^2 * 1024)), r = integer fifth root of n*2^50/d.
  // d is 255 or 510; only evaluated at elaboration to build tables.
  function automatic logic [63:0] gamma_fix(input logic [63:0] num, input logic half_step,
                                            input int lb);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] p5;
    int          b;
    q = div_u64(num << 50, half_step ? 64'd510 : 64'd255);
    r = '0;
    for (b = 10; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      p5 = t * t * t * t * t;
      if (t <= 64'd1024 && p5 <= q) r = t;
    end
    return div_u64((64'd1 << lb) * num * num * r,
                   half_step ? 64'd266342400 : 64'd66585600);
  endfunction

endpackage

@@ hdl/mcbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mcbd_cell.sv @@
// One mip level: geometry, source-position stepping and held left pixel.
// Depends on mcbd_pkg. Geometry ripples to the next cell one level per cycle.
module mcbd_cell import mcbd_pkg::*; #(
  parameter int MAX_DIM      = 4096,
  parameter int MAX_LEVELS   = 12,
  parameter int MAX_CHANNELS = 4,
  parameter int LEVEL        = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        w_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        h_i,
  input  logic [$clog2(2*MAX_DIM)-1:0]        base_i,
  output logic [$clog2(MAX_DIM+1)-1:0]        w_o,
  output logic [$clog2(MAX_DIM+1)-1:0]        h_o,
  output logic [$clog2(2*MAX_DIM)-1:0]        base_o,
  input  logic [$clog2(MAX_DIM+1)-1:0]        col_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]        row_i,
  input  logic [MAX_CHANNELS-1:0][CH_W-1:0]   pix_i,
  input  logic                                hold_i,
  input  logic                                adv_i,
  output cell_info_t                          info_o,
  output logic [$clog2(MAX_DIM+1)-1:0]        x_o,
  output logic [$clog2(MAX_DIM+1)-1:0]        y_o,
  output logic [$clog2(2*MAX_DIM)-1:0]        addr_col_o,
  output logic [$clog2(2*MAX_DIM)-1:0]        addr_sx_o,
  output logic [$clog2(2*MAX_DIM)-1:0]        addr_sx1_o,
  output logic [MAX_CHANNELS-1:0][CH_W-1:0]   held_o
);

  localparam int DIM_W  = $clog2(MAX_DIM+1);
  localparam int ADDR_W = $clog2(2*MAX_DIM);
  localparam int SUM_W  = DIM_W + 1;

  logic [DIM_W-1:0]  w_q, h_q;
  logic [ADDR_W-1:0] base_q;
  logic [DIM_W-1:0]  x_q, y_q, sx_q, sy_q, ax_q, ay_q;
  logic [MAX_CHANNELS-1:0][CH_W-1:0] held_q;

  logic [DIM_W-1:0] nw, nh, sx1, sy1;
  logic [1:0]       step_w, step_h;
  logic             rem_w, rem_h, lvl_on, last_lvl, live;
  logic [SUM_W-1:0] sxp, syp, ax_sum, ay_sum;
  logic             ax_wrap, ay_wrap;
  logic             row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      h_q    <= '0;
      base_q <= '0;
    end else begin
      w_q    <= w_i;
      h_q    <= h_i;
      base_q <= base_i;
    end
  end

  // next-level size and the exact W/NW step: quotient and remainder
  always_comb begin
    nw = (w_q > DIM_W'(1)) ? (w_q >> 1) : DIM_W'(1);
    nh = (h_q > DIM_W'(1)) ? (h_q >> 1) : DIM_W'(1);
    if (w_q <= DIM_W'(1)) begin
      step_w = 2'd1; rem_w = 1'b0;
    end else if (w_q == DIM_W'(3)) begin
      step_w = 2'd3; rem_w = 1'b0;
    end else begin
      step_w = 2'd2; rem_w = w_q[0];
    end
    if (h_q <= DIM_W'(1)) begin
      step_h = 2'd1; rem_h = 1'b0;
    end else if (h_q == DIM_W'(3)) begin
      step_h = 2'd3; rem_h = 1'b0;
    end else begin
      step_h = 2'd2; rem_h = h_q[0];
    end
  end

  assign lvl_on   = (w_q > DIM_W'(1)) || (h_q > DIM_W'(1));
  assign last_lvl = (LEVEL == MAX_LEVELS - 1) || !((nw > DIM_W'(1)) || (nh > DIM_W'(1)));
  assign live     = lvl_on && (y_q < nh) && (x_q < nw);

  assign sxp = SUM_W'(sx_q) + SUM_W'(1);
  assign syp = SUM_W'(sy_q) + SUM_W'(1);
  assign sx1 = (sxp < SUM_W'(w_q)) ? sxp[DIM_W-1:0] : sx_q;
  assign sy1 = (syp < SUM_W'(h_q)) ? syp[DIM_W-1:0] : sy_q;

  always_comb begin
    info_o.act = ACT_DROP;
    if (live) begin
      if (row_i == sy_q && row_i != sy1) begin
        info_o.act = ACT_STORE;
      end else if (row_i == sy1) begin
        if (col_i == sx_q && col_i != sx1) info_o.act = ACT_HOLD;
        else if (col_i == sx1)             info_o.act = ACT_EMIT;
      end
    end
    info_o.same_row = (sy_q == sy1);
    info_o.same_col = (sx_q == sx1);
    info_o.final_px = last_lvl && (x_q == nw - DIM_W'(1)) && (y_q == nh - DIM_W'(1));
  end

  assign row_end = (x_q == nw - DIM_W'(1));
  assign ax_sum  = SUM_W'(ax_q) + SUM_W'(rem_w);
  assign ay_sum  = SUM_W'(ay_q) + SUM_W'(rem_h);
  assign ax_wrap = ax_sum >= SUM_W'(nw);
  assign ay_wrap = ay_sum >= SUM_W'(nh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      sx_q <= '0;
      sy_q <= '0;
      ax_q <= '0;
      ay_q <= '0;
    end else if (clear_i) begin
      x_q  <= '0;
      y_q  <= '0;
      sx_q <= '0;
      sy_q <= '0;
      ax_q <= '0;
      ay_q <= '0;
    end else if (adv_i) begin
      if (row_end) begin
        x_q  <= '0;
        ax_q <= '0;
        sx_q <= '0;
        y_q  <= y_q + DIM_W'(1);
        ay_q <= DIM_W'(ay_wrap ? ay_sum - SUM_W'(nh) : ay_sum);
        sy_q <= sy_q + DIM_W'(step_h) + DIM_W'(ay_wrap);
      end else begin
        x_q  <= x_q + DIM_W'(1);
        ax_q <= DIM_W'(ax_wrap ? ax_sum - SUM_W'(nw) : ax_sum);
        sx_q <= sx_q + DIM_W'(step_w) + DIM_W'(ax_wrap);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_i) held_q <= pix_i;
  end

  assign w_o        = nw;
  assign h_o        = nh;
  assign base_o     = base_q + ADDR_W'(w_q);
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign addr_col_o = base_q + ADDR_W'(col_i);
  assign addr_sx_o  = base_q + ADDR_W'(sx_q);
  assign addr_sx1_o = base_q + ADDR_W'(sx1);
  assign held_o     = held_q;

endmodule

@@ hdl/mcbd_blend.sv @@
// 2x2 averaging unit: plain rounded mean, or sRGB mean through linear tables
// with an 8-step binary threshold search. Depends on mcbd_pkg.
module mcbd_blend import mcbd_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int LINEAR_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              srgb_i,
  input  logic [2:0]                        nch_i,
  input  logic [MAX_CHANNELS-1:0][CH_W-1:0] px_a_i,
  input  logic [MAX_CHANNELS-1:0][CH_W-1:0] px_b_i,
  input  logic [MAX_CHANNELS-1:0][CH_W-1:0] px_c_i,
  input  logic [MAX_CHANNELS-1:0][CH_W-1:0] px_d_i,
  output logic                              done_o,
  output logic [MAX_CHANNELS-1:0][CH_W-1:0] res_o
);

  localparam int LIN_W = LINEAR_BITS + 1;
  localparam int LSUM_W = LIN_W + 2;

  typedef logic [LIN_W-1:0] tab_t [256];

  function automatic tab_t build_tab(input logic thr);
    tab_t tab;
    int   k;
    for (k = 0; k < 256; k++) begin
      if (!thr)        tab[k] = LIN_W'(gamma_fix(64'(k), 1'b0, LINEAR_BITS));
      else if (k == 0) tab[k] = '0;
      else             tab[k] = LIN_W'(gamma_fix(64'(2 * k - 1), 1'b1, LINEAR_BITS));
    end
    return tab;
  endfunction

  localparam tab_t LIN_TAB = build_tab(1'b0);
  localparam tab_t THR_TAB = build_tab(1'b1);

  logic       srch_q, done_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      srch_q <= srgb_i;
      done_q <= !srgb_i;
      cnt_q  <= 3'd7;
    end else if (srch_q) begin
      cnt_q <= cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        srch_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;

  for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_ch
    logic [CH_W+1:0] psum;
    logic [CH_W-1:0] res_q;

    assign psum = (CH_W+2)'(px_a_i[j]) + (CH_W+2)'(px_b_i[j]) + (CH_W+2)'(px_c_i[j]) +
                  (CH_W+2)'(px_d_i[j]) + (CH_W+2)'(2);

    always_ff @(posedge clk_i) begin
      if (start_i) res_q <= (j < nch_i) ? psum[CH_W+1:2] : '0;
    end

    if (j < SRGB_CH) begin : g_srgb
      logic [LSUM_W-1:0] lsum;
      logic [LIN_W-1:0]  avg_q;
      logic [7:0]        kres_q, kt;
      logic              use_q;

      assign lsum = LSUM_W'(LIN_TAB[px_a_i[j][7:0]]) + LSUM_W'(LIN_TAB[px_b_i[j][7:0]]) +
                    LSUM_W'(LIN_TAB[px_c_i[j][7:0]]) + LSUM_W'(LIN_TAB[px_d_i[j][7:0]]) +
                    LSUM_W'(2);
      assign kt   = kres_q | (8'd1 << cnt_q);

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          avg_q  <= lsum[LSUM_W-1:2];
          kres_q <= '0;
          use_q  <= srgb_i && (j < nch_i);
        end else if (srch_q && THR_TAB[kt] <= avg_q) begin
          kres_q <= kt;
        end
      end

      assign res_o[j] = use_q ? {8'd0, kres_q} : res_q;
    end else begin : g_plain
      assign res_o[j] = res_q;
    end
  end

endmodule

@@ hdl/mipmap_chain_box_downsampler_unit.sv @@
// Mip-chain box downsampler: one level-0 pixel in, every finished mip pixel out.
// Per source pixel: it ends in a row buffer, a holding register or is unused, or
// it completes one or more levels, each blended as a plain mean or as an sRGB mean
// (8-step threshold search), with row-buffer reads through the single RAM read port.
// Reset is asynchronous active low; after reset and after every write to a register
// index up to REG_SRGB the input stalls while level sizes ripple down the cell chain.
module mipmap_chain_box_downsampler_unit import mcbd_pkg::*; #(
  parameter int MAX_DIM      = 4096,
  parameter int MAX_LEVELS   = 12,
  parameter int MAX_CHANNELS = 4,
  parameter int LINEAR_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // in_ch0, in_ch1, in_ch2, in_ch3
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mip_level, out_x, out_y, out_ch0, out_ch1, out_ch2, out_ch3, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // run_last
  output logic                   m_axis_tlast,
  // chain_done
  output logic                   m_axis_tuser,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DIM_W  = $clog2(MAX_DIM+1);
  localparam int ADDR_W = $clog2(2*MAX_DIM);
  localparam int LVL_W  = $clog2(MAX_LEVELS+1);
  localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SET_W  = $clog2(MAX_LEVELS+2);
  localparam int PIX_W  = CH_W * MAX_CHANNELS;

  typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_RD1, ST_RD2, ST_WAIT} state_e;
  typedef logic [MAX_CHANNELS-1:0][CH_W-1:0] pix_t;

  // configuration
  logic [12:0] cfg_w_q, cfg_h_q;
  logic [2:0]  cfg_nch_q;
  logic        cfg_s16_q, cfg_srgb_q, cfg_hit;
  logic [SET_W-1:0] settle_q;

  assign cfg_hit = cfg_we_i && (cfg_index_i <= REG_SRGB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 13'd4096;
      cfg_h_q    <= 13'd4096;
      cfg_nch_q  <= 3'd4;
      cfg_s16_q  <= 1'b0;
      cfg_srgb_q <= 1'b0;
      settle_q   <= SET_W'(MAX_LEVELS + 1);
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WIDTH:  cfg_w_q    <= cfg_data_i;
          REG_HEIGHT: cfg_h_q    <= cfg_data_i;
          REG_NCH:    cfg_nch_q  <= cfg_data_i[2:0];
          REG_S16:    cfg_s16_q  <= cfg_data_i[0];
          REG_SRGB:   cfg_srgb_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cfg_hit)                    settle_q <= SET_W'(MAX_LEVELS + 1);
      else if (settle_q != '0)        settle_q <= settle_q - SET_W'(1);
    end
  end

  logic [31:0]      w_ext, h_ext;
  logic [DIM_W-1:0] w0, h0;
  logic [2:0]       nch;
  logic             srgb_on;

  assign w_ext   = 32'(cfg_w_q);
  assign h_ext   = 32'(cfg_h_q);
  assign w0      = (w_ext == 32'd0) ? DIM_W'(1) :
                   (w_ext > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(w_ext);
  assign h0      = (h_ext == 32'd0) ? DIM_W'(1) :
                   (h_ext > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(h_ext);
  assign nch     = (cfg_nch_q == 3'd0) ? 3'd1 :
                   (32'(cfg_nch_q) > 32'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : cfg_nch_q;
  assign srgb_on = !cfg_s16_q && cfg_srgb_q;

  // cell chain
  logic [DIM_W-1:0]  geo_w [MAX_LEVELS+1];
  logic [DIM_W-1:0]  geo_h [MAX_LEVELS+1];
  logic [ADDR_W-1:0] geo_b [MAX_LEVELS+1];
  cell_info_t        c_info [MAX_LEVELS];
  logic [DIM_W-1:0]  c_x [MAX_LEVELS];
  logic [DIM_W-1:0]  c_y [MAX_LEVELS];
  logic [ADDR_W-1:0] c_acol [MAX_LEVELS];
  logic [ADDR_W-1:0] c_asx [MAX_LEVELS];
  logic [ADDR_W-1:0] c_asx1 [MAX_LEVELS];
  pix_t              c_held [MAX_LEVELS];

  state_e            state_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [DIM_W-1:0]  tcol_q, trow_q, in_col_q, in_row_q;
  pix_t              tpix_q, tl_q, tr_q, left_q;
  logic              frame_end_q, start_q;
  logic              st_valid_q, st_done_q;
  logic [LVL_OUT_W-1:0] st_lvl_q;
  logic [POS_OUT_W-1:0] st_x_q, st_y_q;
  pix_t              st_pix_q;
  logic              out_valid_q, out_last_q, out_user_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_pack;

  logic              hold_pl, adv_pl, clear_pl, ram_we, eval_go, cur_ok;
  logic              release_st, start_d;
  logic [LIDX_W-1:0] idx;
  cell_act_e         cur_act;
  pix_t              cur_left, in_pix, blend_res;
  logic              blend_done;
  logic [PIX_W-1:0]  ram_rdata;

  assign geo_w[0] = w0;
  assign geo_h[0] = h0;
  assign geo_b[0] = '0;

  for (genvar L = 0; L < MAX_LEVELS; L++) begin : g_cell
    mcbd_cell #(
      .MAX_DIM(MAX_DIM), .MAX_LEVELS(MAX_LEVELS), .MAX_CHANNELS(MAX_CHANNELS), .LEVEL(L)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_pl),
      .w_i        (geo_w[L]),
      .h_i        (geo_h[L]),
      .base_i     (geo_b[L]),
      .w_o        (geo_w[L+1]),
      .h_o        (geo_h[L+1]),
      .base_o     (geo_b[L+1]),
      .col_i      (tcol_q),
      .row_i      (trow_q),
      .pix_i      (tpix_q),
      .hold_i     (hold_pl && (idx == LIDX_W'(L))),
      .adv_i      (adv_pl && (idx == LIDX_W'(L))),
      .info_o     (c_info[L]),
      .x_o        (c_x[L]),
      .y_o        (c_y[L]),
      .addr_col_o (c_acol[L]),
      .addr_sx_o  (c_asx[L]),
      .addr_sx1_o (c_asx1[L]),
      .held_o     (c_held[L])
    );
  end

  assign cur_ok   = (32'(lvl_q) < 32'(MAX_LEVELS));
  assign idx      = LIDX_W'(lvl_q);
  assign cur_act  = cur_ok ? c_info[idx].act : ACT_DROP;
  assign cur_left = c_info[idx].same_col ? tpix_q : c_held[idx];
  assign eval_go  = !st_valid_q || !out_valid_q || m_axis_tready;

  // the staged result moves to the output register on this cycle
  assign release_st = (state_q == ST_EVAL) && eval_go && st_valid_q;
  assign start_d    = ((state_q == ST_EVAL) && eval_go && (cur_act == ACT_EMIT) &&
                       c_info[idx].same_row) || (state_q == ST_RD2);

  always_comb begin
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      if (j < nch) in_pix[j] = cfg_s16_q ? s_axis_tdata[CH_W*j +: CH_W]
                                         : {8'd0, s_axis_tdata[CH_W*j +: 8]};
      else         in_pix[j] = '0;
    end
  end

  always_comb begin
    out_pack = '0;
    out_pack[LVL_OUT_W-1:0] = st_lvl_q;
    out_pack[LVL_OUT_W +: POS_OUT_W] = st_x_q;
    out_pack[LVL_OUT_W+POS_OUT_W +: POS_OUT_W] = st_y_q;
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      out_pack[LVL_OUT_W + 2*POS_OUT_W + CH_W*j +: CH_W] = st_pix_q[j];
    end
  end

  always_comb begin
    hold_pl  = 1'b0;
    adv_pl   = 1'b0;
    ram_we   = 1'b0;
    clear_pl = cfg_hit;
    if (state_q == ST_EVAL && eval_go) begin
      case (cur_act)
        ACT_STORE: ram_we  = 1'b1;
        ACT_HOLD:  hold_pl = 1'b1;
        default: ;
      endcase
      if (cur_act != ACT_EMIT && frame_end_q) clear_pl = 1'b1;
    end
    if (state_q == ST_WAIT && blend_done) adv_pl = 1'b1;
  end

  mcbd_ram #(.WIDTH(PIX_W), .DEPTH(2*MAX_DIM)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_acol[idx]),
    .wdata_i (tpix_q),
    .raddr_i ((state_q == ST_RD1) ? c_asx1[idx] : c_asx[idx]),
    .rdata_o (ram_rdata)
  );

  mcbd_blend #(.MAX_CHANNELS(MAX_CHANNELS), .LINEAR_BITS(LINEAR_BITS)) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .srgb_i  (srgb_on),
    .nch_i   (nch),
    .px_a_i  (tl_q),
    .px_b_i  (tr_q),
    .px_c_i  (left_q),
    .px_d_i  (tpix_q),
    .done_o  (blend_done),
    .res_o   (blend_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      tcol_q      <= '0;
      trow_q      <= '0;
      tpix_q      <= '0;
      tl_q        <= '0;
      tr_q        <= '0;
      left_q      <= '0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      frame_end_q <= 1'b0;
      start_q     <= 1'b0;
      st_valid_q  <= 1'b0;
      st_done_q   <= 1'b0;
      st_lvl_q    <= '0;
      st_x_q      <= '0;
      st_y_q      <= '0;
      st_pix_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_user_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      start_q <= start_d;
      if (release_st)                        out_valid_q <= 1'b1;
      else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_hit) begin
        in_col_q    <= '0;
        in_row_q    <= '0;
        frame_end_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            tpix_q <= in_pix;
            tcol_q <= in_col_q;
            trow_q <= in_row_q;
            lvl_q  <= '0;
            if (in_col_q == w0 - DIM_W'(1)) begin
              in_col_q <= '0;
              if (in_row_q == h0 - DIM_W'(1)) begin
                in_row_q    <= '0;
                frame_end_q <= 1'b1;
              end else begin
                in_row_q <= in_row_q + DIM_W'(1);
              end
            end else begin
              in_col_q <= in_col_q + DIM_W'(1);
            end
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            // release the previous level's result; it is last unless this level emits
            if (st_valid_q) begin
              out_data_q  <= out_pack;
              out_last_q  <= (cur_act != ACT_EMIT);
              out_user_q  <= st_done_q;
              st_valid_q  <= 1'b0;
            end
            if (cur_act == ACT_EMIT) begin
              left_q <= cur_left;
              if (c_info[idx].same_row) begin
                tl_q    <= cur_left;
                tr_q    <= tpix_q;
                state_q <= ST_WAIT;
              end else begin
                state_q <= ST_RD1;
              end
            end else begin
              frame_end_q <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_RD1: begin
          tl_q    <= ram_rdata;
          state_q <= ST_RD2;
        end
        ST_RD2: begin
          tr_q    <= ram_rdata;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (blend_done) begin
            st_valid_q <= 1'b1;
            st_lvl_q   <= LVL_OUT_W'(lvl_q) + LVL_OUT_W'(1);
            st_x_q     <= POS_OUT_W'(c_x[idx]);
            st_y_q     <= POS_OUT_W'(c_y[idx]);
            st_done_q  <= c_info[idx].final_px;
            st_pix_q   <= blend_res;
            tpix_q     <= blend_res;
            tcol_q     <= c_x[idx];
            trow_q     <= c_y[idx];
            lvl_q      <= lvl_q + LVL_W'(1);
            state_q    <= ST_EVAL;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE) && (settle_q == '0);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ hdl/mcbd_checker.sv @@
// Port-level checks for the mip-chain box downsampler, bound to the top level.
// Depends on mcbd_pkg and mipmap_chain_box_downsampler_unit.
module mcbd_checker import mcbd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser,
  input logic                   cfg_we_i,
  input logic [CFG_IDX_W-1:0]   cfg_index_i,
  input logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // a stalled result request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // the final 1x1 pixel always closes its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("chain_done without run_last");

  a_level_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[LVL_OUT_W-1:0] != '0)
    else $error("result with level zero");

  // geometry ripples after a register write, so input must stall
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i <= REG_SRGB) |=> !s_axis_tready)
    else $error("input taken right after register write");

endmodule

bind mipmap_chain_box_downsampler_unit mcbd_checker u_mcbd_checker (.*);
